[rtl/core/matrix_multiply_top_defines.svh]
// Assertion macros shared by the matrix multiply checker.
`ifndef MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mm_pkg.sv]
// Types, constants and helper functions of the matrix multiply unit.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int VAL_W      = 32;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [1:0] OP_WRITE_A  = 2'd0;
    localparam logic [1:0] OP_WRITE_B  = 2'd1;
    localparam logic [1:0] OP_MULTIPLY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        row_sel;
        logic [IDX_W-1:0]        col_sel;
        logic signed [VAL_W-1:0] elem_value;
    } mm_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } mm_out_t;

    // Clamped sizes of one multiply command.
    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } mm_cmd_t;

    typedef struct packed {
        logic              a_en;
        logic              b_en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } mm_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mm_q_status_t;

    typedef struct packed {
        logic busy;
    } mm_eng_status_t;

    typedef struct packed {
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } mm_tag_t;

    typedef enum logic {
        ENG_IDLE,
        ENG_RUN
    } mm_eng_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [VAL_W-1:0] r;
        hi = $signed({{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
        lo = $signed({{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
        if (s > hi) begin
            r = $signed({1'b0, {(VAL_W-1){1'b1}}});
        end else if (s < lo) begin
            r = $signed({1'b1, {(VAL_W-1){1'b0}}});
        end else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/matrix_multiply_top.sv]
// Throughput: one multiply-accumulate per cycle while a slot in the four-word result FIFO is
// free to be reserved for each new product element; the engine takes each multiply word from
// the command queue before its products start. Element writes wait for the engine: they are
// taken only when no multiply is queued or running.
// Reset is synchronous and active low; it clears control state and sets all three sizes
// to 8, while the element stores keep their contents and are not cleared.
`timescale 1ns / 1ps

module matrix_multiply_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mm_pkg::mm_in_t                s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mm_pkg::mm_out_t               m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]      cfg_data
);
    import mm_pkg::*;

    mm_q_status_t   q_status;
    mm_eng_status_t eng_status;
    mm_cmd_t        push_cmd;
    mm_cmd_t        head_cmd;
    mm_wr_t         wr;
    logic           push;
    logic           pop;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [VAL_W-1:0]  a_rdata;
    logic [VAL_W-1:0]  b_rdata;

    mm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .eng_status (eng_status),
        .push       (push),
        .push_cmd   (push_cmd),
        .wr         (wr)
    );

    mm_cmd_queue u_cmd_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    mm_ram #(.WIDTH(VAL_W), .DEPTH(MEM_DEPTH)) u_store_a (
        .aclk  (aclk),
        .we    (wr.a_en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_ram #(.WIDTH(VAL_W), .DEPTH(MEM_DEPTH)) u_store_b (
        .aclk  (aclk),
        .we    (wr.b_en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mm_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .eng_status (eng_status),
        .a_raddr    (a_raddr),
        .b_raddr    (b_raddr),
        .a_rdata    (a_rdata),
        .b_rdata    (b_rdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[rtl/core/mm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mm_cmd_queue.sv]
// Short queue of multiply commands between the front end and the engine.
`timescale 1ns / 1ps

module mm_cmd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mm_pkg::mm_cmd_t      push_cmd,
    input  logic                 pop,
    output mm_pkg::mm_cmd_t      head_cmd,
    output mm_pkg::mm_q_status_t status
);
    import mm_pkg::*;

    mm_cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= CMDQ_PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= CMDQ_PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CMDQ_CNT_W'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CMDQ_CNT_W'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[rtl/core/mm_front.sv]
// Front end: takes input words and register writes, stores elements, queues multiplies.
`timescale 1ns / 1ps

module mm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mm_pkg::mm_in_t                s_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
    input  mm_pkg::mm_q_status_t          q_status,
    input  mm_pkg::mm_eng_status_t        eng_status,
    output logic                          push,
    output mm_pkg::mm_cmd_t               push_cmd,
    output mm_pkg::mm_wr_t                wr
);
    import mm_pkg::*;

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_dim_reg;
    logic [DIM_W-1:0] cols_b_reg;
    logic             accept;
    logic             in_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Element writes wait until no multiply is queued or running, so a
    // multiply always sees the stores as they stood when it was accepted.
    always_comb begin
        case (s_data.opcode)
            OP_WRITE_A, OP_WRITE_B: s_ready = q_status.empty && !eng_status.busy;
            OP_MULTIPLY:            s_ready = !q_status.full;
            default:                s_ready = 1'b1;
        endcase
    end

    assign accept   = s_valid && s_ready;
    assign in_range = (s_data.row_sel < MAX_DIM) && (s_data.col_sel < MAX_DIM);

    assign wr.a_en = accept && in_range && (s_data.opcode == OP_WRITE_A);
    assign wr.b_en = accept && in_range && (s_data.opcode == OP_WRITE_B);
    assign wr.addr = {s_data.row_sel, s_data.col_sel};
    assign wr.data = s_data.elem_value;

    assign push        = accept && (s_data.opcode == OP_MULTIPLY);
    assign push_cmd.nr = clamp_dim(rows_a_reg);
    assign push_cmd.nk = clamp_dim(inner_dim_reg);
    assign push_cmd.nc = clamp_dim(cols_b_reg);

endmodule

[rtl/core/mm_engine.sv]
// Back end: multiply-accumulate pipeline, saturation and result FIFO.
`timescale 1ns / 1ps

module mm_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mm_pkg::mm_q_status_t          q_status,
    input  mm_pkg::mm_cmd_t               head_cmd,
    output logic                          pop,
    output mm_pkg::mm_eng_status_t        eng_status,
    output logic [mm_pkg::ADDR_W-1:0]     a_raddr,
    output logic [mm_pkg::ADDR_W-1:0]     b_raddr,
    input  logic [mm_pkg::VAL_W-1:0]      a_rdata,
    input  logic [mm_pkg::VAL_W-1:0]      b_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mm_pkg::mm_out_t               m_data
);
    import mm_pkg::*;

    mm_eng_state_t         state_reg, state_next;
    mm_cmd_t               dims_reg, dims_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [OUT_CNT_W-1:0]  credit_reg, credit_next;
    logic                  issue;
    logic                  i_last, j_last, k_last;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    mm_tag_t                 s1_tag_reg, s2_tag_reg, s3_tag_reg;
    mm_tag_t                 s0_tag;
    logic signed [VAL_W-1:0] a_val, b_val;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_add;

    mm_out_t               fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  fifo_wr_reg;
    logic [OUT_PTR_W-1:0]  fifo_rd_reg;
    logic [OUT_CNT_W-1:0]  fifo_cnt_reg;
    logic                  fifo_push, fifo_pop;
    mm_out_t               fifo_in;

    assign i_last = (DIM_W'(i_reg) == DIM_W'(dims_reg.nr - 1'b1));
    assign j_last = (DIM_W'(j_reg) == DIM_W'(dims_reg.nc - 1'b1));
    assign k_last = (DIM_W'(k_reg) == DIM_W'(dims_reg.nk - 1'b1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ENG_IDLE;
            credit_reg <= OUT_CNT_W'(OUT_DEPTH);
        end else begin
            state_reg  <= state_next;
            credit_reg <= credit_next;
        end
        dims_reg <= dims_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
    end

    // A new product element starts only when a result FIFO slot is
    // reserved for it, so the pipeline itself never has to stall.
    always_comb begin
        state_next = state_reg;
        dims_next  = dims_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            ENG_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    dims_next  = head_cmd;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ENG_RUN;
                end
            end
            ENG_RUN: begin
                if (k_reg != '0 || credit_reg != '0) begin
                    issue = 1'b1;
                    if (k_last) begin
                        k_next = '0;
                        if (j_last) begin
                            j_next = '0;
                            if (i_last) begin
                                i_next     = '0;
                                state_next = ENG_IDLE;
                            end else begin
                                i_next = IDX_W'(i_reg + 1'b1);
                            end
                        end else begin
                            j_next = IDX_W'(j_reg + 1'b1);
                        end
                    end else begin
                        k_next = IDX_W'(k_reg + 1'b1);
                    end
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    assign fifo_pop    = m_valid && m_ready;
    assign credit_next = OUT_CNT_W'(credit_reg - OUT_CNT_W'(issue && k_reg == '0)
                                    + OUT_CNT_W'(fifo_pop));

    assign eng_status.busy = (state_reg == ENG_RUN);
    assign a_raddr = {i_reg, k_reg};
    assign b_raddr = {k_reg, j_reg};

    assign s0_tag.first = (k_reg == '0);
    assign s0_tag.lastk = k_last;
    assign s0_tag.row   = i_reg;
    assign s0_tag.col   = j_reg;
    assign s0_tag.last  = i_last && j_last;

    assign a_val   = a_rdata;
    assign b_val   = b_rdata;
    assign acc_add = ACC_W'(prod_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
        s1_tag_reg <= s0_tag;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        prod_reg   <= a_val * b_val;
        if (s2_valid_reg) begin
            acc_reg <= (s2_tag_reg.first ? '0 : acc_reg) + acc_add;
        end
    end

    assign fifo_push         = s3_valid_reg && s3_tag_reg.lastk;
    assign fifo_in.out_row   = s3_tag_reg.row;
    assign fifo_in.out_col   = s3_tag_reg.col;
    assign fifo_in.out_value = sat_val(acc_reg);
    assign fifo_in.last      = s3_tag_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (fifo_push) begin
                fifo_wr_reg <= OUT_PTR_W'(fifo_wr_reg + 1'b1);
            end
            if (fifo_pop) begin
                fifo_rd_reg <= OUT_PTR_W'(fifo_rd_reg + 1'b1);
            end
            if (fifo_push && !fifo_pop) begin
                fifo_cnt_reg <= OUT_CNT_W'(fifo_cnt_reg + 1'b1);
            end else if (fifo_pop && !fifo_push) begin
                fifo_cnt_reg <= OUT_CNT_W'(fifo_cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_reg[fifo_wr_reg] <= fifo_in;
        end
    end

    assign m_valid = (fifo_cnt_reg != '0);
    assign m_data  = fifo_reg[fifo_rd_reg];

endmodule

[rtl/core/mm_checker.sv]
// Port-level checker for the matrix multiply unit, bound to the top level.
`timescale 1ns / 1ps
`include "matrix_multiply_top_defines.svh"

module mm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input mm_pkg::mm_out_t               m_data,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [mm_pkg::DIM_W-1:0]      cfg_data
);
    import mm_pkg::*;

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [IDX_W-1:0] last_row;
    logic [IDX_W-1:0] last_col;
    logic             at_last_pos;

    // Shadow copy of the row and column size registers, seen through the write port only.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_ROWS_A) begin
                rows_reg <= cfg_data;
            end
            if (cfg_index == REG_COLS_B) begin
                cols_reg <= cfg_data;
            end
        end
    end

    assign last_row    = IDX_W'(clamp_dim(rows_reg) - 1'b1);
    assign last_col    = IDX_W'(clamp_dim(cols_reg) - 1'b1);
    assign at_last_pos = (m_data.out_row == last_row) && (m_data.out_col == last_col);

    `MM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result word dropped while stalled")
    `MM_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_data), "stalled result changed")
    `MM_ASSERT_NOW(a_last_pos, m_valid && m_data.last, at_last_pos, "last flag misplaced")
    `MM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write refused")

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);
